### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Clocked property checks with reset gating, reported by $error.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/eucd_pkg.sv
// ---------------------------------------------------------------------------
// eucd_pkg
// Types and constants of the Elias universal code decoder.
// ---------------------------------------------------------------------------
package eucd_pkg;

    // Value width limit of decoded integers
    localparam int VALUE_BITS = 32;
    localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;

    // Overflow limits on the count of prefix zeros already taken and on delta length
    localparam logic [31:0] UNARY_ZERO_LIMIT = 32'((64'd1 << VW) - 64'd2);
    localparam logic [31:0] GAMMA_ZERO_LIMIT = 32'(VW - 1);
    localparam logic [31:0] DELTA_ZERO_LIMIT = (VW >= 32) ? 32'd5 :
                                               (VW >= 16) ? 32'd4 : 32'd3;
    localparam logic [32:0] DELTA_LEN_LIMIT  = 33'(VW);

    // Code kinds
    localparam logic [1:0] KIND_UNARY  = 2'd0;
    localparam logic [1:0] KIND_GAMMA  = 2'd1;
    localparam logic [1:0] KIND_BINARY = 2'd2;
    localparam logic [1:0] KIND_DELTA  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_TRUNC = 2'd1;
    localparam logic [1:0] ST_OVF   = 2'd2;

    // Configuration register indexes
    localparam int          CFG_IDX_W    = 2;
    localparam logic [1:0]  CFG_CODE_KIND = 2'd0;
    localparam logic [1:0]  CFG_BIN_RANGE = 2'd1;

    typedef struct packed {
        logic code_bit;
        logic stream_end;
    } in_word_t;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } out_word_t;

    // Decoder settings derived at configuration time
    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  bin_len_m1;   // ceil(log2(b)) - 1
        logic [31:0] bin_thresh;   // 2^ceil(log2(b)) - b
        logic        clear;        // abandon any open codeword
    } cfg_t;

    typedef struct packed {
        logic      valid;
        out_word_t word;
    } result_t;

endpackage

### rtl/eucd_cfg.sv
// ---------------------------------------------------------------------------
// eucd_cfg
// Configuration registers; derives truncated binary length and threshold.
// ---------------------------------------------------------------------------
module eucd_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [eucd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    output eucd_pkg::cfg_t                 cfg
);
    import eucd_pkg::*;

    logic [1:0]  kind_reg;
    logic [5:0]  len_m1_reg;
    logic [31:0] thresh_reg;
    logic [5:0]  len_m1_next;
    logic [31:0] thresh_next;
    logic [31:0] range_eff;
    logic [31:0] range_m1;
    logic [5:0]  range_len;
    logic [32:0] pow_len;

    // Bit length of (b - 1) over the clamped range, and the length and threshold from it
    always_comb
    begin
        range_eff = (cfg_data < 32'd2) ? 32'd2 : cfg_data;
        range_m1  = range_eff - 32'd1;
        range_len = 6'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (range_m1[i])
            begin
                range_len = 6'(i + 1);
            end
        end
        pow_len     = 33'd1 << range_len;
        len_m1_next = range_len - 6'd1;
        thresh_next = 32'(pow_len - {1'b0, range_eff});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg   <= KIND_GAMMA;
            len_m1_reg <= 6'd0;
            thresh_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CODE_KIND:
                begin
                    kind_reg <= cfg_data[1:0];
                end
                CFG_BIN_RANGE:
                begin
                    len_m1_reg <= len_m1_next;
                    thresh_reg <= thresh_next;
                end
                default:
                begin
                    kind_reg <= kind_reg;
                end
            endcase
        end
    end

    assign cfg.kind       = kind_reg;
    assign cfg.bin_len_m1 = len_m1_reg;
    assign cfg.bin_thresh = thresh_reg;
    assign cfg.clear      = cfg_we && ((cfg_index == CFG_CODE_KIND) ||
                                       (cfg_index == CFG_BIN_RANGE));

endmodule

### rtl/eucd_core.sv
// ---------------------------------------------------------------------------
// eucd_core
// Codeword state and the one-bit decode step.
// ---------------------------------------------------------------------------
module eucd_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  eucd_pkg::in_word_t word,
    input  eucd_pkg::cfg_t     cfg,
    output eucd_pkg::result_t  result
);
    import eucd_pkg::*;

    typedef enum logic [3:0] {
        PH_PREFIX = 4'b0001,
        PH_BODY   = 4'b0010,
        PH_SUFFIX = 4'b0100,
        PH_BINARY = 4'b1000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] zeros_reg, zeros_next;
    logic [32:0] acc_reg, acc_next;
    logic [5:0]  left_reg, left_next;

    logic [32:0] acc_sh;
    logic [5:0]  left_dec;
    logic        prefix_ovf;
    logic [32:0] bin_acc_in;
    logic [5:0]  bin_left_in;
    logic [32:0] bin_sh;
    logic [5:0]  bin_left_dec;
    logic        bin_below;
    logic [32:0] bin_diff;
    logic [31:0] bin_final;
    logic        open_cw;
    result_t     res;

    always_comb
    begin
        acc_sh   = {acc_reg[31:0], word.code_bit};
        left_dec = left_reg - 6'd1;

        case (cfg.kind)
            KIND_UNARY: prefix_ovf = (zeros_reg >= UNARY_ZERO_LIMIT);
            KIND_GAMMA: prefix_ovf = (zeros_reg >= GAMMA_ZERO_LIMIT);
            default:    prefix_ovf = (zeros_reg >= DELTA_ZERO_LIMIT);
        endcase

        // Binary step starts fresh from the prefix phase
        bin_acc_in   = (phase_reg == PH_PREFIX) ? 33'd0 : acc_reg;
        bin_left_in  = (phase_reg == PH_PREFIX) ? cfg.bin_len_m1 : left_reg;
        bin_sh       = {bin_acc_in[31:0], word.code_bit};
        bin_left_dec = bin_left_in - 6'd1;
        bin_below    = (bin_sh < {1'b0, cfg.bin_thresh});
        bin_diff     = bin_below ? 33'd0 : (bin_sh - {1'b0, cfg.bin_thresh});
        bin_final    = 32'(bin_diff + 33'd1);

        open_cw = (phase_reg != PH_PREFIX) || (zeros_reg != 32'd0);
    end

    always_comb
    begin
        phase_next      = phase_reg;
        zeros_next      = zeros_reg;
        acc_next        = acc_reg;
        left_next       = left_reg;
        res.valid       = 1'b0;
        res.word.value  = 32'd0;
        res.word.status = ST_OK;

        if (word.stream_end)
        begin
            res.valid       = open_cw;
            res.word.status = ST_TRUNC;
        end
        else
        begin
            case (phase_reg)
                PH_PREFIX:
                begin
                    if (cfg.kind == KIND_BINARY)
                    begin
                        if (bin_left_in == 6'd0)
                        begin
                            res.valid      = 1'b1;
                            res.word.value = bin_final;
                        end
                        else if ((bin_left_dec == 6'd0) && bin_below)
                        begin
                            res.valid      = 1'b1;
                            res.word.value = 32'(bin_sh + 33'd1);
                        end
                        else
                        begin
                            phase_next = PH_BINARY;
                            acc_next   = bin_sh;
                            left_next  = bin_left_dec;
                        end
                    end
                    else if (!word.code_bit)
                    begin
                        if (prefix_ovf)
                        begin
                            res.valid       = 1'b1;
                            res.word.status = ST_OVF;
                        end
                        else
                        begin
                            zeros_next = zeros_reg + 32'd1;
                        end
                    end
                    else if (cfg.kind == KIND_UNARY)
                    begin
                        res.valid      = 1'b1;
                        res.word.value = zeros_reg + 32'd1;
                    end
                    else if (zeros_reg == 32'd0)
                    begin
                        res.valid      = 1'b1;
                        res.word.value = 32'd1;
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                        acc_next   = 33'd1;
                        left_next  = zeros_reg[5:0];
                    end
                end
                PH_BODY:
                begin
                    acc_next  = acc_sh;
                    left_next = left_dec;
                    if (left_dec == 6'd0)
                    begin
                        if (cfg.kind != KIND_DELTA)
                        begin
                            res.valid      = 1'b1;
                            res.word.value = acc_sh[31:0];
                        end
                        else if (acc_sh > DELTA_LEN_LIMIT)
                        begin
                            res.valid       = 1'b1;
                            res.word.status = ST_OVF;
                        end
                        else if (acc_sh == 33'd1)
                        begin
                            res.valid      = 1'b1;
                            res.word.value = 32'd1;
                        end
                        else
                        begin
                            // Length known: read its low bits under an implied one
                            phase_next = PH_SUFFIX;
                            acc_next   = 33'd1;
                            left_next  = acc_sh[5:0] - 6'd1;
                        end
                    end
                end
                PH_SUFFIX:
                begin
                    acc_next  = acc_sh;
                    left_next = left_dec;
                    if (left_dec == 6'd0)
                    begin
                        res.valid      = 1'b1;
                        res.word.value = acc_sh[31:0];
                    end
                end
                PH_BINARY:
                begin
                    if (bin_left_in == 6'd0)
                    begin
                        res.valid      = 1'b1;
                        res.word.value = bin_final;
                    end
                    else if ((bin_left_dec == 6'd0) && bin_below)
                    begin
                        res.valid      = 1'b1;
                        res.word.value = 32'(bin_sh + 33'd1);
                    end
                    else
                    begin
                        // Another bit follows; past the short length only when at or above the threshold
                        acc_next  = bin_sh;
                        left_next = bin_left_dec;
                    end
                end
                default:
                begin
                    phase_next = PH_PREFIX;
                end
            endcase
        end

        // Any result or stream end closes the codeword
        if (word.stream_end || res.valid)
        begin
            phase_next = PH_PREFIX;
            zeros_next = 32'd0;
            acc_next   = 33'd0;
            left_next  = 6'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PREFIX;
            zeros_reg <= 32'd0;
            acc_reg   <= 33'd0;
            left_reg  <= 6'd0;
        end
        else if (cfg.clear)
        begin
            phase_reg <= PH_PREFIX;
            zeros_reg <= 32'd0;
            acc_reg   <= 33'd0;
            left_reg  <= 6'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            zeros_reg <= zeros_next;
            acc_reg   <= acc_next;
            left_reg  <= left_next;
        end
    end

    assign result.valid = accept && res.valid;
    assign result.word  = res.word;

endmodule

### rtl/eucd_obuf.sv
// ---------------------------------------------------------------------------
// eucd_obuf
// Result register with a skid stage; holds the input side off when full.
// ---------------------------------------------------------------------------
module eucd_obuf
(
    input  logic                clk,
    input  logic                rst_n,
    input  eucd_pkg::result_t   result,
    input  logic                res_stall,
    output logic                res_valid,
    output eucd_pkg::out_word_t res_word,
    output logic                full
);
    import eucd_pkg::*;

    logic      main_valid_reg;
    out_word_t main_reg;
    logic      skid_valid_reg;
    out_word_t skid_reg;
    logic      take;

    assign take = main_valid_reg && !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // Input is held off; drain the skid word first
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (result.valid)
        begin
            if (main_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (result.valid)
        begin
            if (main_valid_reg && !take)
            begin
                skid_reg <= result.word;
            end
            else
            begin
                main_reg <= result.word;
            end
        end
    end

    assign res_valid = main_valid_reg;
    assign res_word  = main_reg;
    assign full      = skid_valid_reg;

endmodule

### rtl/elias_universal_code_decoder_top.sv
// ---------------------------------------------------------------------------
// elias_universal_code_decoder_top
// Bit-serial decoder for unary, gamma, truncated binary and delta codes.
//
// Input channel (bit_valid / bit_stall / bit_word) carries one code bit per
// word, or an end-of-stream mark. A word is taken on a rising edge with
// bit_valid high and bit_stall low. Each taken word advances the codeword
// state in that same cycle; a word that completes a codeword, overflows it or
// ends an open one yields one result word.
// Output channel (res_valid / res_stall / res_word) carries value and status.
// The closing bit's result is registered in the result register or the skid word.
// Throughput: one input word per cycle while bit_stall is low.
// A result register plus a skid word decouple the two sides: input is taken
// while a result waits, and bit_stall rises only once both are full.
// Receiver stall holds res_word steady and, after the skid fills, stalls input.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the next
// edge and drop any open codeword. Reset selects gamma, range 2, no codeword
// open, and empties the result stages.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module elias_universal_code_decoder_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [eucd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           bit_valid,
    output logic                           bit_stall,
    input  eucd_pkg::in_word_t             bit_word,
    output logic                           res_valid,
    input  logic                           res_stall,
    output eucd_pkg::out_word_t            res_word
);
    import eucd_pkg::*;

    cfg_t    cfg;
    result_t result;
    logic    accept;
    logic    full;

    assign bit_stall = full;
    assign accept    = bit_valid && !full;

    eucd_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    eucd_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .word   (bit_word),
        .cfg    (cfg),
        .result (result)
    );

    eucd_obuf u_obuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (result),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .res_word  (res_word),
        .full      (full)
    );

    `ASSERT_CLK(a_skid_needs_main, bit_stall |-> res_valid, "skid full without a result held")
    `ASSERT_CLK(a_status_code, res_valid |-> (res_word.status == ST_OK || res_word.status == ST_TRUNC || res_word.status == ST_OVF), "undefined status code")
    `ASSERT_CLK(a_fail_value_zero, (res_valid && res_word.status != ST_OK) |-> (res_word.value == 32'd0), "failed result carries a value")
    `ASSERT_NEVER(a_result_when_full, result.valid && full, "result produced while skid full")

endmodule

### tb/elias_universal_code_decoder_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// elias_universal_code_decoder_top_tb
// Self-checking bench for the bit-serial universal code decoder.
//
// Feeds code bits through a bursty driver while the result side stalls on
// its own pattern. Unary, gamma, truncated binary and delta streams are
// built from random values, mixed with cut-off codewords, overflowing
// prefixes, loose bits and end marks. A cycle model of the decoder, updated
// on every accepted bit and register write, predicts each result word.
// ---------------------------------------------------------------------------
module elias_universal_code_decoder_top_tb;
    import eucd_pkg::*;

    typedef enum logic [1:0] {PH_PREFIX, PH_BODY, PH_SUFFIX, PH_BINARY} dec_phase_t;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] range;
    } code_setting_t;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
    localparam int N_SETTINGS   = 15;
    localparam int SETTING_BITS = 62;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;
    logic                 bit_valid = 1'b0;
    logic                 bit_stall;
    in_word_t             bit_word  = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    out_word_t            res_word;

    elias_universal_code_decoder_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bit_valid (bit_valid),
        .bit_stall (bit_stall),
        .bit_word  (bit_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

    in_word_t  stream_q[$];
    out_word_t decoded_q[$];
    bit        cw_bits[$];

    // decoder model state
    logic [1:0]  dec_kind;
    logic [31:0] dec_range;
    dec_phase_t  dec_phase;
    logic [31:0] dec_zeros;
    logic [63:0] dec_acc;
    int          dec_left;
    int          dec_slog;

    int err_count;
    int items_queued;
    int words_in;
    int cfg_writes;
    int n_ok;
    int n_trunc;
    int n_ovf;

    int burst_left;
    int gap_left;
    int stall_mode;
    int mode_left;
    int run_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("elias_universal_code_decoder_top test failed");
        $finish;
    end

    task automatic report_error(input string msg);
        err_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic int bit_len(input logic [31:0] v);
        int k;
        k = 0;
        while (v != 0)
        begin
            v = v >> 1;
            k++;
        end
        return k;
    endfunction

    task automatic clear_codeword();
        dec_phase = PH_PREFIX;
        dec_zeros = '0;
        dec_acc   = '0;
        dec_left  = 0;
        dec_slog  = 0;
    endtask

    task automatic apply_config(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        if (idx == CFG_CODE_KIND)
        begin
            dec_kind = data[1:0];
            clear_codeword();
        end
        else if (idx == CFG_BIN_RANGE)
        begin
            dec_range = data;
            clear_codeword();
        end
    endtask

    // Advance the decoder model by one word; got marks a result word in r.
    task automatic decode_step(input in_word_t w, output bit got, output out_word_t r);
        logic [31:0] b;
        logic [63:0] thresh;
        logic [63:0] q;
        logic [31:0] z;
        bit          ovf;
        got    = 1'b0;
        r      = '0;
        b      = (dec_range < 32'd2) ? 32'd2 : dec_range;
        thresh = (64'd1 << bit_len(b - 32'd1)) - 64'(b);
        if (w.stream_end)
        begin
            if (dec_phase != PH_PREFIX || dec_zeros != 0)
            begin
                got      = 1'b1;
                r.status = ST_TRUNC;
            end
            clear_codeword();
            return;
        end
        // binary codewords have no prefix: the first bit already belongs to the body
        if (dec_phase == PH_PREFIX && dec_kind == KIND_BINARY)
        begin
            dec_phase = PH_BINARY;
            dec_acc   = '0;
            dec_left  = bit_len(b - 32'd1) - 1;
        end
        case (dec_phase)
            PH_PREFIX:
            begin
                if (!w.code_bit)
                begin
                    z = dec_zeros + 32'd1;
                    if (dec_kind == KIND_UNARY)
                        ovf = 64'(z) >= (64'd1 << VW) - 64'd1;
                    else if (dec_kind == KIND_GAMMA)
                        ovf = z >= VW;
                    else
                        ovf = z >= 6 || (64'd1 << z) > VW;
                    if (ovf)
                    begin
                        got      = 1'b1;
                        r.status = ST_OVF;
                    end
                    else
                        dec_zeros = z;
                end
                else if (dec_kind == KIND_UNARY)
                begin
                    got     = 1'b1;
                    r.value = dec_zeros + 32'd1;
                end
                else if (dec_zeros == 0)
                begin
                    got     = 1'b1;
                    r.value = 32'd1;
                end
                else
                begin
                    dec_acc   = 64'd1;
                    dec_left  = dec_zeros;
                    dec_phase = PH_BODY;
                end
            end
            PH_BODY:
            begin
                dec_acc = {dec_acc[62:0], w.code_bit};
                dec_left--;
                if (dec_left == 0)
                begin
                    got = 1'b1;
                    if (dec_kind != KIND_DELTA)
                        r.value = dec_acc[31:0];
                    else if (dec_acc > VW)
                        r.status = ST_OVF;
                    else if (dec_acc == 64'd1)
                        r.value = 32'd1;
                    else
                    begin
                        // length known: read the low bits under an implied leading one
                        got       = 1'b0;
                        dec_slog  = int'(dec_acc) - 1;
                        dec_acc   = 64'd1;
                        dec_left  = dec_slog;
                        dec_phase = PH_SUFFIX;
                    end
                end
            end
            PH_SUFFIX:
            begin
                dec_acc = {dec_acc[62:0], w.code_bit};
                dec_left--;
                if (dec_left == 0)
                begin
                    got     = 1'b1;
                    r.value = dec_acc[31:0];
                end
            end
            default:
            begin
                dec_acc = {dec_acc[62:0], w.code_bit} & 64'h1_FFFF_FFFF;
                if (dec_left != 0)
                begin
                    dec_left--;
                    if (dec_left == 0 && dec_acc < thresh)
                    begin
                        got     = 1'b1;
                        r.value = dec_acc[31:0] + 32'd1;
                    end
                end
                else
                begin
                    q       = (dec_acc >= thresh) ? dec_acc - thresh : 64'd0;
                    got     = 1'b1;
                    r.value = q[31:0] + 32'd1;
                end
            end
        endcase
        if (got)
            clear_codeword();
    endtask

    // ---------------- stream building ----------------

    task automatic push_word(input bit code_bit, input bit stream_end);
        in_word_t w;
        w.code_bit   = code_bit;
        w.stream_end = stream_end;
        stream_q.push_back(w);
        items_queued++;
    endtask

    task automatic push_end();
        push_word($urandom_range(0, 1), 1'b1);
    endtask

    task automatic push_bits(input int from, input int upto);
        for (int i = from; i < upto; i++)
            push_word(cw_bits[i], 1'b0);
    endtask

    task automatic add_gamma(input logic [31:0] v);
        int n;
        n = bit_len(v);
        repeat (n - 1) cw_bits.push_back(1'b0);
        for (int i = n - 1; i >= 0; i--)
            cw_bits.push_back(v[i]);
    endtask

    task automatic build_codeword(input logic [1:0] kind, input logic [31:0] range,
                                  input logic [31:0] v);
        logic [31:0] b;
        logic [63:0] thresh;
        logic [63:0] x;
        int          n;
        int          k;
        cw_bits.delete();
        case (kind)
            KIND_UNARY:
            begin
                repeat (v - 1) cw_bits.push_back(1'b0);
                cw_bits.push_back(1'b1);
            end
            KIND_GAMMA:
                add_gamma(v);
            KIND_DELTA:
            begin
                n = bit_len(v);
                add_gamma(n);
                for (int i = n - 2; i >= 0; i--)
                    cw_bits.push_back(v[i]);
            end
            default:
            begin
                b      = (range < 32'd2) ? 32'd2 : range;
                k      = bit_len(b - 32'd1);
                thresh = (64'd1 << k) - 64'(b);
                x      = 64'(v) - 64'd1;
                if (x < thresh)
                    for (int i = k - 2; i >= 0; i--)
                        cw_bits.push_back(x[i]);
                else
                begin
                    x = x + thresh;
                    for (int i = k - 1; i >= 0; i--)
                        cw_bits.push_back(x[i]);
                end
            end
        endcase
    endtask

    task automatic build_overflow(input logic [1:0] kind);
        cw_bits.delete();
        if (kind == KIND_GAMMA)
            repeat (VW) cw_bits.push_back(1'b0);
        else if ($urandom_range(0, 1) == 0)
            repeat (DELTA_ZERO_LIMIT + 1) cw_bits.push_back(1'b0);
        else
            add_gamma($urandom_range(VW + 1, (2 << DELTA_ZERO_LIMIT) - 1));
    endtask

    function automatic logic [31:0] pick_value(input logic [1:0] kind, input logic [31:0] range);
        logic [31:0] b;
        logic [31:0] v;
        int          n;
        b = (range < 32'd2) ? 32'd2 : range;
        case (kind)
            KIND_UNARY:
                v = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 90) : $urandom_range(1, 24);
            KIND_BINARY:
                case ($urandom_range(0, 9))
                    0:       v = 32'd1;
                    1:       v = b;
                    default: v = $urandom_range(1, b);
                endcase
            default:
                case ($urandom_range(0, 19))
                    0:       v = 32'd1;
                    1:       v = 32'hFFFF_FFFF;
                    default:
                    begin
                        // mostly short values, now and then full width
                        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 6);
                        v = $urandom();
                        if (n < 32)
                            v = v & ((32'd1 << n) - 32'd1);
                        v[n - 1] = 1'b1;
                    end
                endcase
        endcase
        return v;
    endfunction

    task automatic wait_idle();
        do
            @(negedge clk);
        while (stream_q.size() != 0 || bit_valid || decoded_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_writes++;
    endtask

    task automatic fill_setting(input logic [1:0] kind, input logic [31:0] range, input int target);
        int stop;
        int sel;
        int cut;
        stop = items_queued + target;
        @(negedge clk);
        while (items_queued < stop)
        begin
            sel = $urandom_range(0, 99);
            build_codeword(kind, range, pick_value(kind, range));
            if (sel < 76)
                push_bits(0, cw_bits.size());
            else if (sel < 84)
            begin
                // cut the codeword short, then end the stream
                push_bits(0, $urandom_range(0, cw_bits.size() - 1));
                push_end();
            end
            else if (sel < 91)
            begin
                if (kind == KIND_GAMMA || kind == KIND_DELTA)
                    build_overflow(kind);
                push_bits(0, cw_bits.size());
            end
            else if (sel < 95)
                repeat ($urandom_range(1, 6)) push_word($urandom_range(0, 1), 1'b0);
            else if (sel < 98)
                push_end();
            else
            begin
                // hold mid-codeword, write a spare index, then finish the codeword
                cut = $urandom_range(0, cw_bits.size() - 1);
                push_bits(0, cut);
                wait_idle();
                write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom());
                @(negedge clk);
                push_bits(cut, cw_bits.size());
            end
        end
        // leave a codeword open now and then for the next register write to drop
        if ($urandom_range(0, 1) == 0)
        begin
            build_codeword(kind, range, pick_value(kind, range));
            push_bits(0, $urandom_range(0, cw_bits.size() - 1));
        end
    endtask

    // ---------------- driver ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_valid  <= 1'b0;
            bit_word   <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!bit_valid || !bit_stall)
        begin
            if (gap_left != 0)
            begin
                gap_left  <= gap_left - 1;
                bit_valid <= 1'b0;
            end
            else if (stream_q.size() != 0)
            begin
                bit_word  <= stream_q.pop_front();
                bit_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 48);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                bit_valid <= 1'b0;
        end
    end

    // ---------------- result stall pattern ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall  <= 1'b0;
            stall_mode <= 0;
            mode_left  <= 100;
            run_left   <= 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(50, 300);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0: res_stall <= 1'b0;
                1: res_stall <= ($urandom_range(0, 3) == 0);
                2: res_stall <= ($urandom_range(0, 9) < 7);
                default:
                begin
                    if (run_left == 0)
                    begin
                        res_stall <= !res_stall;
                        run_left  <= res_stall ? $urandom_range(1, 4) : $urandom_range(1, 20);
                    end
                    else
                        run_left <= run_left - 1;
                end
            endcase
        end
    end

    // ---------------- monitor and checker ----------------

    always @(posedge clk)
    begin : result_monitor
        bit        got;
        out_word_t r;
        out_word_t want;
        if (rst_n)
        begin
            if (cfg_we)
                apply_config(cfg_index, cfg_data);
            if (bit_valid && !bit_stall)
            begin
                words_in++;
                decode_step(bit_word, got, r);
                if (got)
                    decoded_q.push_back(r);
            end
            if (res_valid && !res_stall)
            begin
                if (decoded_q.size() == 0)
                    report_error($sformatf("unexpected word value %0h status %0d",
                                           res_word.value, res_word.status));
                else
                begin
                    want = decoded_q.pop_front();
                    if (res_word.value !== want.value)
                        report_error($sformatf("value %0h, want %0h", res_word.value, want.value));
                    if (res_word.status !== want.status)
                        report_error($sformatf("status %0d, want %0d", res_word.status,
                                               want.status));
                    case (want.status)
                        ST_OK:    n_ok++;
                        ST_TRUNC: n_trunc++;
                        default:  n_ovf++;
                    endcase
                end
            end
        end
    end

    // ---------------- stimulus ----------------

    initial
    begin : stimulus
        code_setting_t plan [N_SETTINGS];
        logic [31:0]   rng;
        dec_kind  = KIND_GAMMA;
        dec_range = 32'd2;
        clear_codeword();
        plan = '{'{KIND_UNARY, 32'd0}, '{KIND_GAMMA, 32'd0}, '{KIND_DELTA, 32'd0},
                 '{KIND_BINARY, 32'd2}, '{KIND_BINARY, 32'd3}, '{KIND_BINARY, 32'd0},
                 '{KIND_BINARY, 32'd1}, '{KIND_BINARY, 32'd5}, '{KIND_BINARY, 32'd1000},
                 '{KIND_BINARY, 32'h8000_0001}, '{KIND_BINARY, 32'hFFFF_FFFF},
                 '{KIND_BINARY, 32'd0}, '{KIND_DELTA, 32'd0}, '{KIND_GAMMA, 32'd0},
                 '{KIND_UNARY, 32'd0}};
        plan[11].range = $urandom_range(7, 300);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset setting is gamma: short codewords and both kinds of cut-off
        push_word(1'b1, 1'b0);
        push_word(1'b0, 1'b0);
        push_word(1'b1, 1'b0);
        push_word(1'b0, 1'b0);
        build_codeword(KIND_GAMMA, 32'd2, 32'd5);
        push_bits(0, cw_bits.size());
        push_word(1'b1, 1'b1);
        push_word(1'b0, 1'b0);
        push_word(1'b0, 1'b0);
        push_word(1'b0, 1'b1);
        push_word(1'b0, 1'b0);
        push_word(1'b1, 1'b0);
        push_word(1'b1, 1'b1);
        push_word(1'b0, 1'b1);

        for (int i = 0; i < N_SETTINGS; i++)
        begin
            wait_idle();
            rng = (plan[i].kind == KIND_BINARY) ? plan[i].range : $urandom();
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(CFG_CODE_KIND, ($urandom() & 32'hFFFF_FFFC) | 32'(plan[i].kind));
                write_reg(CFG_BIN_RANGE, rng);
            end
            else
            begin
                write_reg(CFG_BIN_RANGE, rng);
                write_reg(CFG_CODE_KIND, ($urandom() & 32'hFFFF_FFFC) | 32'(plan[i].kind));
            end
            fill_setting(plan[i].kind, rng, SETTING_BITS);
        end

        wait_idle();
        repeat (20) @(negedge clk);
        $display("covered %0d bit words over %0d code settings with %0d register writes",
                 words_in, N_SETTINGS + 1, cfg_writes);
        $display("results checked: %0d decoded, %0d cut off by stream end, %0d overflowed",
                 n_ok, n_trunc, n_ovf);
        if (err_count == 0 && decoded_q.size() == 0)
            $display("elias_universal_code_decoder_top test passed");
        else
            $display("elias_universal_code_decoder_top test failed");
        $finish;
    end

endmodule
